// ----- hw/rtl/pcq_pkg.sv -----
// shared types and constants for the per-class queue block
// no dependencies; used by pcq_ctrl, pcq_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package pcq_pkg;

    localparam int NUM_QUEUES  = 16;
    localparam int DEPTH       = 8;
    localparam int ID_BITS     = 16;

    localparam int ENTRY_COUNT = NUM_QUEUES * DEPTH;
    localparam int QW          = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int AW          = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SERVE = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED  = 2'd0,
        ST_FULL   = 2'd1,
        ST_SERVED = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        logic               urgent;
        logic [ID_BITS-1:0] id;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } pcq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } pcq_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pcq_ctrl.sv -----
// sequencing state machine for the per-class queue block
// depends on pcq_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pcq_pkg::pcq_stat_t stat,
    output pcq_pkg::pcq_cmd_t      ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        ctl.capture = 1'b0;
        ctl.exec    = 1'b0;
        ctl.load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // wait for the output register to free up
                if (!stat.out_busy)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef NO_ASSERTIONS
    a_load_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> (state_reg == S_LOAD))
        else $error("exec not followed by load state");
    a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.capture |=> ctl.exec)
        else $error("captured request not executed next cycle");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/pcq_datapath.sv -----
// queue storage, per-queue head and count registers, result register
// depends on pcq_pkg; driven by pcq_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module pcq_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcq_pkg::pcq_cmd_t ctl,
    output pcq_pkg::pcq_stat_t     stat,
    input  wire logic              cmd,
    input  wire logic [3:0]        queue_id,
    input  wire logic [15:0]       entry_id,
    input  wire logic              is_urgent,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output logic [15:0]            served_id,
    output logic                   served_urgent,
    output logic [3:0]             count_after
);

    // latched request
    logic                        cmd_reg;
    logic [3:0]                  q_reg;
    logic [pcq_pkg::ID_BITS-1:0] id_reg;
    logic                        urg_reg;

    // per-queue state
    logic [pcq_pkg::CW-1:0] counts_reg [pcq_pkg::NUM_QUEUES];
    logic [pcq_pkg::PW-1:0] heads_reg  [pcq_pkg::NUM_QUEUES];

    // entry storage
    pcq_pkg::entry_t mem [pcq_pkg::ENTRY_COUNT];
    pcq_pkg::entry_t rd_reg;

    // result of the executed request
    pcq_pkg::status_t       res_status_reg;
    logic [pcq_pkg::CW-1:0] res_count_reg;

    // output register
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] served_id_reg;
    logic        served_urgent_reg;
    logic [3:0]  count_after_reg;

    logic                   q_ok;
    logic [pcq_pkg::QW-1:0] qi;
    logic [pcq_pkg::CW-1:0] n;
    logic [pcq_pkg::PW-1:0] h;
    logic [pcq_pkg::PW-1:0] h_dec;
    logic [pcq_pkg::PW-1:0] h_inc;
    logic [pcq_pkg::PW-1:0] tail;
    int                     tail_sum;

    pcq_pkg::status_t       st_next;
    logic [pcq_pkg::CW-1:0] cnt_next;
    logic [pcq_pkg::PW-1:0] head_next;
    logic                   state_we;
    logic                   mem_we;
    logic                   mem_re;
    logic [pcq_pkg::PW-1:0] ptr;
    logic [pcq_pkg::AW-1:0] mem_addr;
    pcq_pkg::entry_t        wdata;

    assign q_ok = (int'(q_reg) < pcq_pkg::NUM_QUEUES);
    assign qi   = pcq_pkg::QW'(q_reg);
    assign n    = counts_reg[qi];
    assign h    = heads_reg[qi];

    // ring pointer arithmetic, head operands below DEPTH and count at most DEPTH
    assign h_dec    = (int'(h) == 0) ? pcq_pkg::PW'(pcq_pkg::DEPTH - 1)
                                     : pcq_pkg::PW'(int'(h) - 1);
    assign h_inc    = (int'(h) == pcq_pkg::DEPTH - 1) ? '0 : pcq_pkg::PW'(int'(h) + 1);
    assign tail_sum = int'(h) + int'(n);
    assign tail     = (tail_sum >= pcq_pkg::DEPTH) ? pcq_pkg::PW'(tail_sum - pcq_pkg::DEPTH)
                                                   : pcq_pkg::PW'(tail_sum);

    always_comb
    begin
        st_next   = pcq_pkg::ST_EMPTY;
        cnt_next  = '0;
        head_next = h;
        state_we  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        ptr       = h;
        wdata     = '{urgent: urg_reg, id: id_reg};
        if (!q_ok)
        begin
            // no such queue: refuse adds, serve reports empty
            st_next = (cmd_reg == pcq_pkg::CMD_SERVE) ? pcq_pkg::ST_EMPTY
                                                      : pcq_pkg::ST_FULL;
        end
        else if (cmd_reg == pcq_pkg::CMD_ADD)
        begin
            if (int'(n) >= pcq_pkg::DEPTH)
            begin
                st_next  = pcq_pkg::ST_FULL;
                cnt_next = n;
            end
            else
            begin
                st_next  = pcq_pkg::ST_ADDED;
                cnt_next = pcq_pkg::CW'(int'(n) + 1);
                state_we = 1'b1;
                mem_we   = 1'b1;
                if (urg_reg)
                begin
                    // urgent entry goes ahead of everything queued
                    head_next = h_dec;
                    ptr       = h_dec;
                end
                else
                begin
                    ptr = tail;
                end
            end
        end
        else
        begin
            if (int'(n) == 0)
            begin
                st_next = pcq_pkg::ST_EMPTY;
            end
            else
            begin
                st_next   = pcq_pkg::ST_SERVED;
                cnt_next  = pcq_pkg::CW'(int'(n) - 1);
                head_next = h_inc;
                state_we  = 1'b1;
                mem_re    = 1'b1;
            end
        end
    end

    assign mem_addr = pcq_pkg::AW'(int'(qi) * pcq_pkg::DEPTH + int'(ptr));

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd;
            q_reg   <= queue_id;
            id_reg  <= pcq_pkg::ID_BITS'(entry_id);
            urg_reg <= is_urgent;
        end
        if (ctl.exec)
        begin
            res_status_reg <= st_next;
            res_count_reg  <= cnt_next;
        end
        if (ctl.exec && mem_we)
            mem[mem_addr] <= wdata;
        if (ctl.exec && mem_re)
            rd_reg <= mem[mem_addr];
        if (ctl.load)
        begin
            status_reg      <= res_status_reg;
            count_after_reg <= 4'(res_count_reg);
            if (res_status_reg == pcq_pkg::ST_SERVED)
            begin
                served_id_reg     <= 16'(rd_reg.id);
                served_urgent_reg <= rd_reg.urgent;
            end
            else
            begin
                served_id_reg     <= '0;
                served_urgent_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pcq_pkg::NUM_QUEUES; i++)
            begin
                counts_reg[i] <= '0;
                heads_reg[i]  <= '0;
            end
        end
        else if (ctl.exec && state_we)
        begin
            counts_reg[qi] <= cnt_next;
            heads_reg[qi]  <= head_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign served_id     = served_id_reg;
    assign served_urgent = served_urgent_reg;
    assign count_after   = count_after_reg;

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> !(out_valid_reg && !out_ready))
        else $error("result loaded over an untaken result");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && q_ok) |-> (int'(n) <= pcq_pkg::DEPTH))
        else $error("queue count above depth");
    a_zero_when_not_served: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != pcq_pkg::ST_SERVED)
            |-> (served_id_reg == '0 && !served_urgent_reg))
        else $error("served fields nonzero on a non-serve result");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/per_class_queue_with_urgent_front_core.sv -----
// each request is captured, executed against its queue and then loaded into the output register;
// the load waits while the output register holds a result that out_ready has not yet taken
// in_ready is high only in idle, so a new request is accepted only after the previous one is loaded
// a new request is taken while the previous result still waits in the output register
// reset: queue counts and head pointers clear at once; entry storage is not cleared
// top level of the per-class queue block; depends on pcq_pkg, pcq_ctrl, pcq_datapath
`timescale 1ns / 1ps
`default_nettype none

module per_class_queue_with_urgent_front_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [3:0]  queue_id,
    input  wire logic [15:0] entry_id,
    input  wire logic        is_urgent,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [15:0]      served_id,
    output logic             served_urgent,
    output logic [3:0]       count_after
);

    // each queue is a ring inside its own slice of the storage:
    // a normal add writes at head + count, an urgent add moves head back one
    // and writes there, a serve reads at head and moves head forward
    pcq_pkg::pcq_cmd_t  ctl;
    pcq_pkg::pcq_stat_t stat;

    // sequencer: idle, execute against the addressed queue, load result
    pcq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // storage, pointers, counts and the output register
    pcq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd           (cmd),
        .queue_id      (queue_id),
        .entry_id      (entry_id),
        .is_urgent     (is_urgent),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .served_id     (served_id),
        .served_urgent (served_urgent),
        .count_after   (count_after)
    );

endmodule

`default_nettype wire
